// ===== rtl/mksc_pkg.sv =====
package mksc_pkg;

	typedef logic signed [1:0] order_t;

	localparam order_t ORD_BEFORE = 2'sb11;
	localparam order_t ORD_EQUAL  = 2'sb00;
	localparam order_t ORD_AFTER  = 2'sb01;

	typedef enum logic [3:0] {
		TY_INT8     = 4'd0,
		TY_INT16    = 4'd1,
		TY_INT32    = 4'd2,
		TY_INT64    = 4'd3,
		TY_UINT8    = 4'd4,
		TY_UINT16   = 4'd5,
		TY_UINT32   = 4'd6,
		TY_UINT64   = 4'd7,
		TY_FLOAT    = 4'd8,
		TY_DOUBLE   = 4'd9,
		TY_DATE     = 4'd10,
		TY_DATETIME = 4'd11,
		TY_TIME     = 4'd12
	} key_type_t;

	typedef enum logic [2:0] {
		KIND_SIGNED,
		KIND_UNSIGNED,
		KIND_FLOAT,
		KIND_TIME,
		KIND_NONE
	} key_kind_t;

	typedef enum logic [1:0] {
		REG_KEY_TYPE  = 2'd0,
		REG_DESCEND   = 2'd1,
		REG_NULLS     = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_index_t;

	localparam int unsigned REG_SLOTS = 8;
	localparam logic [63:0] TIME_TOP  = 64'h8000_0000_0000_0000;

	localparam logic [63:0] FLT_EXPO  = 64'h0000_0000_7F80_0000;
	localparam logic [63:0] FLT_MANT  = 64'h0000_0000_007F_FFFF;
	localparam logic [63:0] DBL_EXPO  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] DBL_MANT  = 64'h000F_FFFF_FFFF_FFFF;

endpackage

// ===== rtl/multi_key_sort_comparator.sv =====
// A key transfer is captured in the input register; the row result then passes to the
// result register. Throughput: one key transfer per cycle, except while the last key of
// a row waits in the input register on an untaken result; the row result is emitted on
// the key that carries last_key. The compare is one 64-bit magnitude compare per key.
// Reset (arst_n low, asynchronous): configuration registers cleared to zero, key position
// zero, decided order equal, no transfer pending.
module multi_key_sort_comparator #(
	parameter int unsigned MAX_KEYS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// key pair channel
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [63:0]        value_a,
	input  logic [63:0]        value_b,
	input  logic               last_key,
	// row result channel
	output logic               result_valid,
	input  logic               result_ready,
	output mksc_pkg::order_t   order,
	output logic               a_less
);
	import mksc_pkg::*;

	// position counter saturates at MAX_KEYS, so it needs room for MAX_KEYS itself
	localparam int unsigned PW        = $clog2(MAX_KEYS + 1);
	localparam int unsigned KEY_LIMIT = (MAX_KEYS < REG_SLOTS) ? MAX_KEYS : REG_SLOTS;

	// configuration registers
	logic [31:0] key_type_q;
	logic [7:0]  descend_q;
	logic [7:0]  nulls_q;

	// row state: position of the next key to arrive and the order decided so far
	logic [PW-1:0] pos_q;
	order_t        decided_q;

	// input register
	logic          valid_s1;
	logic [63:0]   a_s1;
	logic [63:0]   b_s1;
	logic          last_s1;
	logic [PW-1:0] pos_s1;

	// result register
	logic   out_valid_q;
	order_t order_q;

	logic   s1_adv;
	order_t key_res;
	order_t row_res;

	//------------------------------------------------------------------
	// Configuration port: zero wait states, write on the access phase.
	//------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_type_q <= '0;
			descend_q  <= '0;
			nulls_q    <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_index_t'(paddr[3:2]))
				REG_KEY_TYPE: key_type_q <= pwdata;
				REG_DESCEND:  descend_q  <= pwdata[7:0];
				REG_NULLS:    nulls_q    <= pwdata[7:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_index_t'(paddr[3:2]))
			REG_KEY_TYPE: prdata = key_type_q;
			REG_DESCEND:  prdata = {24'd0, descend_q};
			REG_NULLS:    prdata = {24'd0, nulls_q};
			default:      prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Handshake. The input register drains unless it holds the last key
	// of a row and the result register is still waiting for its transfer.
	//------------------------------------------------------------------
	assign s1_adv     = valid_s1 && (!last_s1 || !out_valid_q || result_ready);
	assign item_ready = !valid_s1 || s1_adv;

	// Stamp each key with its position as it enters; the counter sits at
	// MAX_KEYS for keys past the end, which are then ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (item_valid && item_ready) begin
			if (last_key) begin
				pos_q <= '0;
			end else if (pos_q < PW'(MAX_KEYS)) begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			a_s1    <= value_a;
			b_s1    <= value_b;
			last_s1 <= last_key;
			pos_s1  <= pos_q;
		end
	end

	//------------------------------------------------------------------
	// Per-key compare. Each type maps both values onto unsigned keys so a
	// single magnitude compare decides:
	//   signed  - flip the sign bit
	//   float   - negative: invert all bits; positive: set the sign bit
	//   time    - flip the top bit; both negative: drop the top bit and invert the order
	// Null sentinels are checked first and ignore the direction bit.
	//------------------------------------------------------------------
	logic [31:0] pos_ext;
	logic [2:0]  pos_idx;
	logic        key_live;
	key_type_t   ty;
	key_kind_t   kind;
	logic [63:0] mask;
	logic [63:0] sign;
	logic [63:0] nul;
	logic [63:0] expo;
	logic [63:0] mant;
	logic [63:0] am;
	logic [63:0] bm;
	logic [63:0] ka;
	logic [63:0] kb;
	logic        na;
	logic        nb;
	logic        force_eq;
	logic        inv;
	logic        flip;
	logic        gt;
	logic        lt;

	always_comb begin
		pos_ext  = 32'(pos_s1);
		pos_idx  = pos_ext[2:0];
		key_live = pos_ext < KEY_LIMIT;
		ty       = key_type_t'(key_type_q[{pos_idx, 2'b00} +: 4]);

		kind = KIND_NONE;
		mask = '0;
		sign = '0;
		nul  = '0;
		case (ty)
			TY_INT8: begin
				kind = KIND_SIGNED;   mask = 64'hFF;        sign = 64'h80;
				nul  = 64'h80;
			end
			TY_INT16: begin
				kind = KIND_SIGNED;   mask = 64'hFFFF;      sign = 64'h8000;
				nul  = 64'h8000;
			end
			TY_INT32: begin
				kind = KIND_SIGNED;   mask = 64'hFFFF_FFFF; sign = 64'h8000_0000;
				nul  = 64'h8000_0000;
			end
			TY_INT64: begin
				kind = KIND_SIGNED;   mask = '1;            sign = TIME_TOP;
				nul  = TIME_TOP;
			end
			TY_UINT8: begin
				kind = KIND_UNSIGNED; mask = 64'hFF;        sign = 64'h80;
				nul  = 64'hFE;
			end
			TY_UINT16: begin
				kind = KIND_UNSIGNED; mask = 64'hFFFF;      sign = 64'h8000;
				nul  = 64'hFFFE;
			end
			TY_UINT32, TY_DATE: begin
				kind = KIND_UNSIGNED; mask = 64'hFFFF_FFFF; sign = 64'h8000_0000;
				nul  = 64'hFFFF_FFFE;
			end
			TY_UINT64, TY_DATETIME: begin
				kind = KIND_UNSIGNED; mask = '1;            sign = TIME_TOP;
				nul  = 64'hFFFF_FFFF_FFFF_FFFE;
			end
			TY_FLOAT: begin
				kind = KIND_FLOAT;    mask = 64'hFFFF_FFFF; sign = 64'h8000_0000;
				nul  = 64'hFFAA_AAAA;
			end
			TY_DOUBLE: begin
				kind = KIND_FLOAT;    mask = '1;            sign = TIME_TOP;
				nul  = 64'hFFFA_AAAA_AAAA_AAAA;
			end
			TY_TIME: begin
				kind = KIND_TIME;     mask = '1;            sign = TIME_TOP;
				nul  = 64'hFFFF_FFFF_FFFF_FFFE;
			end
			default: kind = KIND_NONE;
		endcase

		expo = (ty == TY_DOUBLE) ? DBL_EXPO : FLT_EXPO;
		mant = (ty == TY_DOUBLE) ? DBL_MANT : FLT_MANT;

		am = a_s1 & mask;
		bm = b_s1 & mask;
		na = (am == nul);
		nb = (bm == nul);

		ka       = am;
		kb       = bm;
		force_eq = 1'b0;
		inv      = 1'b0;
		case (kind)
			KIND_SIGNED: begin
				ka = am ^ sign;
				kb = bm ^ sign;
			end
			KIND_UNSIGNED: begin
				ka = am;
				kb = bm;
			end
			KIND_FLOAT: begin
				// NaN on either side, or +0 against -0, compares equal
				force_eq = (((am & expo) == expo) && ((am & mant) != '0)) ||
					(((bm & expo) == expo) && ((bm & mant) != '0)) ||
					(((am & ~sign) == '0) && ((bm & ~sign) == '0));
				ka = ((am & sign) != '0) ? (~am & mask) : (am | sign);
				kb = ((bm & sign) != '0) ? (~bm & mask) : (bm | sign);
			end
			KIND_TIME: begin
				if (((am & TIME_TOP) != '0) && ((bm & TIME_TOP) != '0)) begin
					ka  = am & ~TIME_TOP;
					kb  = bm & ~TIME_TOP;
					inv = 1'b1;
				end else begin
					ka = am ^ TIME_TOP;
					kb = bm ^ TIME_TOP;
				end
			end
			default: force_eq = 1'b1;
		endcase

		gt   = ka > kb;
		lt   = ka < kb;
		flip = inv ^ descend_q[pos_idx];

		if (!key_live || kind == KIND_NONE) begin
			key_res = ORD_EQUAL;
		end else if (na || nb) begin
			if (na && nb) begin
				key_res = ORD_EQUAL;
			end else if (nb) begin
				key_res = nulls_q[pos_idx] ? ORD_BEFORE : ORD_AFTER;
			end else begin
				key_res = nulls_q[pos_idx] ? ORD_AFTER : ORD_BEFORE;
			end
		end else if (force_eq || (!gt && !lt)) begin
			key_res = ORD_EQUAL;
		end else if (gt ^ flip) begin
			key_res = ORD_AFTER;
		end else begin
			key_res = ORD_BEFORE;
		end
	end

	// first nonzero key wins
	assign row_res = (decided_q != ORD_EQUAL) ? decided_q : key_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decided_q <= ORD_EQUAL;
		end else if (s1_adv) begin
			decided_q <= last_s1 ? ORD_EQUAL : row_res;
		end
	end

	//------------------------------------------------------------------
	// Result register: load on the last key, drop on transfer.
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_adv && last_s1) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			order_q <= row_res;
		end
	end

	assign result_valid = out_valid_q;
	assign order        = order_q;
	assign a_less       = (order_q == ORD_BEFORE);

endmodule

// ===== rtl/mksc_checker.sv =====
module mksc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pready,
	input logic             item_ready,
	input logic             result_valid,
	input logic             result_ready,
	input mksc_pkg::order_t order,
	input logic             a_less
);
	import mksc_pkg::*;

	// a_less mirrors a "before" order
	a_less_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (a_less == (order == ORD_BEFORE)))
		else $error("a_less disagrees with order");

	// order is one of the three legal codes while result_valid is high
	order_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (order == ORD_BEFORE || order == ORD_EQUAL || order == ORD_AFTER))
		else $error("illegal order code");

	// stalled result holds
	result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(order) && $stable(a_less))
		else $error("result changed while stalled");

	// an empty result register never blocks the key input
	input_open: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("key input blocked with no result waiting");

	// no wait states on the register port
	pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind multi_key_sort_comparator mksc_checker u_mksc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.order        (order),
	.a_less       (a_less)
);
